@@ design/radial_energy_spectrum_binner_unit_assert.svh @@
// assertion macros for the spectrum binner
// expects clk and rst_n in the scope where a macro is used
`ifndef RADIAL_ENERGY_SPECTRUM_BINNER_UNIT_ASSERT_SVH
`define RADIAL_ENERGY_SPECTRUM_BINNER_UNIT_ASSERT_SVH

// same-cycle implication
`define RESB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RESB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/resb_pkg.sv @@
// shared types and constants for the spectrum binner
// no dependencies
package resb_pkg;

  localparam int MUL_W      = 32;
  localparam int COMP_W     = 24;
  localparam int IDX_W      = 6;
  localparam int RAD_W      = 13;  // kx^2 + ky^2 with both at most 63
  localparam int ROOT_W     = 7;   // floor sqrt of that stays below 128
  localparam int ENERGY_W   = 49;  // four 47-bit squares
  localparam int BIN_W      = 64;
  localparam int ACC_W      = 96;
  localparam int CFG_IDX_W  = 2;
  localparam int SHIFT_W    = 7;
  localparam int CNT_W      = 3;
  localparam int NUM_COMPS  = 4;

  localparam logic [SHIFT_W-1:0] SCALE_FRAC_BITS = 7'd16;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVENUMBER_SCALE = 2'd2;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } resb_mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KX,
    ST_COL,
    ST_RAD,
    ST_ROOT_MUL,
    ST_ROOT_CMP,
    ST_ENERGY,
    ST_BIN_RD,
    ST_BIN_WR,
    ST_RO_RD,
    ST_RO_LOAD,
    ST_RO_MLO,
    ST_RO_MHI,
    ST_RO_ADD,
    ST_RO_SHF,
    ST_RO_OUT
  } resb_state_t;

endpackage

@@ design/radial_energy_spectrum_binner_unit.sv @@
// binning: in_stall is high from accepting a mode until its bin is written or it is dropped;
//   the shared multiplier carries two squarings, seven root trials and four component squares
// readout after a last mode: two split 64x32 multiplies per bin through the same unit, a
//   stalled result beat holds back the next one, GRID_SIZE/2+1 beats, then ready again
// reset clears control and per-bin valid flags; unwritten bins read as zero, no clearing pass
// depends on resb_pkg, resb_ram, resb_mul and the assertion macro header
module radial_energy_spectrum_binner_unit #(
  parameter int GRID_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic signed [23:0] in_ux_real,
  input  logic signed [23:0] in_ux_imag,
  input  logic signed [23:0] in_uy_real,
  input  logic signed [23:0] in_uy_imag,
  input  logic        in_last_mode,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_bin_index,
  output logic [63:0] out_bin_energy,
  output logic [63:0] out_total_energy,
  output logic        out_last_bin,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "radial_energy_spectrum_binner_unit_assert.svh"

  localparam int HALF  = GRID_SIZE / 2;
  localparam int NBINS = HALF + 1;
  localparam int AW    = $clog2(NBINS);

  localparam logic [6:0]    GRID_V  = 7'(GRID_SIZE);
  localparam logic [6:0]    HALF_V  = 7'(HALF);
  localparam logic [6:0]    NBINS_V = 7'(NBINS);
  localparam logic [AW-1:0] LAST_K  = AW'(NBINS - 1);

  // component magnitude, -2^23 maps to 2^23
  function automatic logic [resb_pkg::COMP_W-1:0] comp_mag(
    input logic [resb_pkg::COMP_W-1:0] v
  );
    comp_mag = v[resb_pkg::COMP_W-1] ? (~v + 24'd1) : v;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add64 = s[64] ? '1 : s[63:0];
  endfunction

  resb_pkg::resb_state_t state_r, state_nxt;

  logic [31:0] gain_r, scale_r;
  logic [resb_pkg::SHIFT_W-1:0] shift_r;

  logic [5:0] kx_r, kx_nxt;
  logic [5:0] col_r, col_nxt;
  logic       in_range_r, in_range_nxt;
  logic       last_r, last_nxt;
  logic [resb_pkg::COMP_W-1:0] comp_r [resb_pkg::NUM_COMPS];
  logic [resb_pkg::COMP_W-1:0] comp_nxt [resb_pkg::NUM_COMPS];
  logic [resb_pkg::RAD_W-1:0]    rad_r, rad_nxt;
  logic [resb_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [resb_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [resb_pkg::ENERGY_W-1:0] energy_r, energy_nxt;

  logic [AW-1:0] k_r, k_nxt;
  logic          phase_r, phase_nxt;
  logic [63:0]   opnd_r, opnd_nxt;
  logic [resb_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [63:0]   be_r, be_nxt;
  logic [63:0]   total_r, total_nxt;
  logic [NBINS-1:0] valid_r, valid_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_bin_index_r, out_bin_index_nxt;
  logic [63:0] out_bin_energy_r, out_bin_energy_nxt;
  logic [63:0] out_total_energy_r, out_total_energy_nxt;
  logic        out_last_bin_r, out_last_bin_nxt;

  resb_pkg::resb_mul_req_t mul_req;
  logic [63:0] mul_p;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [6:0]  row7, kx7;
  logic [resb_pkg::ROOT_W-1:0] trial;
  logic        keep;
  logic        slot_free;
  logic [AW-1:0] shell;
  logic [63:0] old_bin;
  logic [resb_pkg::ENERGY_W:0] add_e;
  logic [resb_pkg::SHIFT_W-1:0] shamt;
  logic [resb_pkg::ACC_W-1:0] shifted;
  logic [63:0] shift_res;

  resb_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_p)
  );

  resb_ram #(
    .WIDTH (64),
    .DEPTH (NBINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared helpers
  assign row7      = {1'b0, in_row_index};
  assign kx7       = (row7 <= HALF_V) ? row7 : (GRID_V - row7);
  assign trial     = root_r | (7'd1 << cnt_r);
  assign keep      = in_range_r && (root_r < NBINS_V);
  assign shell     = root_r[AW-1:0];
  assign slot_free = !out_valid_r || !out_stall;
  assign shamt     = phase_r ? resb_pkg::SCALE_FRAC_BITS : shift_r;
  assign shifted   = acc_r >> shamt;
  assign shift_res = (|shifted[resb_pkg::ACC_W-1:64]) ? '1 : shifted[63:0];
  assign add_e     = (col_r != 6'd0) ? {energy_r, 1'b0} : {1'b0, energy_r};

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 32'd65536;
      shift_r <= 7'd16;
      scale_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        resb_pkg::REG_OUTPUT_GAIN:      gain_r  <= cfg_data;
        resb_pkg::REG_GAIN_SHIFT:       shift_r <= cfg_data[resb_pkg::SHIFT_W-1:0];
        resb_pkg::REG_WAVENUMBER_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      resb_pkg::ST_IDLE:     if (in_valid) state_nxt = resb_pkg::ST_KX;
      resb_pkg::ST_KX:       state_nxt = resb_pkg::ST_COL;
      resb_pkg::ST_COL:      state_nxt = resb_pkg::ST_RAD;
      resb_pkg::ST_RAD:      state_nxt = resb_pkg::ST_ROOT_MUL;
      resb_pkg::ST_ROOT_MUL: state_nxt = resb_pkg::ST_ROOT_CMP;
      resb_pkg::ST_ROOT_CMP: begin
        state_nxt = (cnt_r == '0) ? resb_pkg::ST_ENERGY : resb_pkg::ST_ROOT_MUL;
      end
      resb_pkg::ST_ENERGY: begin
        if (cnt_r == 3'(resb_pkg::NUM_COMPS)) state_nxt = resb_pkg::ST_BIN_RD;
      end
      resb_pkg::ST_BIN_RD: begin
        if (keep)        state_nxt = resb_pkg::ST_BIN_WR;
        else if (last_r) state_nxt = resb_pkg::ST_RO_RD;
        else             state_nxt = resb_pkg::ST_IDLE;
      end
      resb_pkg::ST_BIN_WR: state_nxt = last_r ? resb_pkg::ST_RO_RD : resb_pkg::ST_IDLE;
      resb_pkg::ST_RO_RD:   state_nxt = resb_pkg::ST_RO_LOAD;
      resb_pkg::ST_RO_LOAD: state_nxt = resb_pkg::ST_RO_MLO;
      resb_pkg::ST_RO_MLO:  state_nxt = resb_pkg::ST_RO_MHI;
      resb_pkg::ST_RO_MHI:  state_nxt = resb_pkg::ST_RO_ADD;
      resb_pkg::ST_RO_ADD:  state_nxt = resb_pkg::ST_RO_SHF;
      resb_pkg::ST_RO_SHF:  state_nxt = phase_r ? resb_pkg::ST_RO_OUT : resb_pkg::ST_RO_MLO;
      resb_pkg::ST_RO_OUT: begin
        if (slot_free) begin
          state_nxt = (k_r == LAST_K) ? resb_pkg::ST_IDLE : resb_pkg::ST_RO_RD;
        end
      end
      default: state_nxt = resb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall   = (state_r != resb_pkg::ST_IDLE);
    mul_req    = '0;
    ram_we     = 1'b0;
    ram_waddr  = shell;
    ram_wdata  = '0;
    ram_raddr  = k_r;
    old_bin    = valid_r[shell] ? ram_rdata : 64'd0;

    kx_nxt       = kx_r;
    col_nxt      = col_r;
    in_range_nxt = in_range_r;
    last_nxt     = last_r;
    comp_nxt     = comp_r;
    rad_nxt      = rad_r;
    root_nxt     = root_r;
    cnt_nxt      = cnt_r;
    energy_nxt   = energy_r;
    k_nxt        = k_r;
    phase_nxt    = phase_r;
    opnd_nxt     = opnd_r;
    acc_nxt      = acc_r;
    be_nxt       = be_r;
    total_nxt    = total_r;
    valid_nxt    = valid_r;

    out_valid_nxt        = out_valid_r && out_stall;
    out_bin_index_nxt    = out_bin_index_r;
    out_bin_energy_nxt   = out_bin_energy_r;
    out_total_energy_nxt = out_total_energy_r;
    out_last_bin_nxt     = out_last_bin_r;

    unique case (state_r)
      resb_pkg::ST_IDLE: begin
        if (in_valid) begin
          kx_nxt       = kx7[5:0];
          col_nxt      = in_col_index;
          in_range_nxt = (row7 < GRID_V) && ({1'b0, in_col_index} <= HALF_V);
          last_nxt     = in_last_mode;
          comp_nxt[0]  = in_ux_real;
          comp_nxt[1]  = in_ux_imag;
          comp_nxt[2]  = in_uy_real;
          comp_nxt[3]  = in_uy_imag;
          k_nxt        = '0;
          total_nxt    = '0;
        end
      end
      resb_pkg::ST_KX: begin
        mul_req.a = 32'(kx_r);
        mul_req.b = 32'(kx_r);
      end
      resb_pkg::ST_COL: begin
        mul_req.a = 32'(col_r);
        mul_req.b = 32'(col_r);
        rad_nxt   = mul_p[resb_pkg::RAD_W-1:0];
      end
      resb_pkg::ST_RAD: begin
        rad_nxt  = rad_r + mul_p[resb_pkg::RAD_W-1:0];
        root_nxt = '0;
        cnt_nxt  = 3'(resb_pkg::ROOT_W - 1);
      end
      resb_pkg::ST_ROOT_MUL: begin
        mul_req.a = 32'(trial);
        mul_req.b = 32'(trial);
      end
      resb_pkg::ST_ROOT_CMP: begin
        if (mul_p <= 64'(rad_r)) root_nxt = trial;
        if (cnt_r != '0) cnt_nxt = cnt_r - 3'd1;
      end
      resb_pkg::ST_ENERGY: begin
        // square issued for component cnt, product of cnt-1 summed
        if (cnt_r < 3'(resb_pkg::NUM_COMPS)) begin
          mul_req.a = 32'(comp_mag(comp_r[cnt_r[1:0]]));
          mul_req.b = 32'(comp_mag(comp_r[cnt_r[1:0]]));
        end
        energy_nxt = (cnt_r == '0) ? '0 :
                     energy_r + resb_pkg::ENERGY_W'(mul_p[47:0]);
        cnt_nxt    = cnt_r + 3'd1;
      end
      resb_pkg::ST_BIN_RD: begin
        ram_raddr = shell;
      end
      resb_pkg::ST_BIN_WR: begin
        ram_we           = 1'b1;
        ram_wdata        = sat_add64(old_bin, 64'(add_e));
        valid_nxt[shell] = 1'b1;
      end
      resb_pkg::ST_RO_RD: begin
        ram_raddr = k_r;
      end
      resb_pkg::ST_RO_LOAD: begin
        opnd_nxt  = valid_r[k_r] ? ram_rdata : 64'd0;
        phase_nxt = 1'b0;
      end
      resb_pkg::ST_RO_MLO: begin
        mul_req.a = opnd_r[31:0];
        mul_req.b = phase_r ? scale_r : gain_r;
      end
      resb_pkg::ST_RO_MHI: begin
        mul_req.a = opnd_r[63:32];
        mul_req.b = phase_r ? scale_r : gain_r;
        acc_nxt   = {32'd0, mul_p};
      end
      resb_pkg::ST_RO_ADD: begin
        acc_nxt = acc_r + {mul_p, 32'd0};
      end
      resb_pkg::ST_RO_SHF: begin
        if (!phase_r) begin
          be_nxt    = shift_res;
          opnd_nxt  = shift_res;
          phase_nxt = 1'b1;
        end else begin
          total_nxt = sat_add64(total_r, shift_res);
        end
      end
      resb_pkg::ST_RO_OUT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_bin_index_nxt    = 6'(k_r);
          out_bin_energy_nxt   = be_r;
          out_total_energy_nxt = total_r;
          out_last_bin_nxt     = (k_r == LAST_K);
          valid_nxt[k_r]       = 1'b0;
          k_nxt                = k_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= resb_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kx_r               <= kx_nxt;
    col_r              <= col_nxt;
    in_range_r         <= in_range_nxt;
    last_r             <= last_nxt;
    comp_r             <= comp_nxt;
    rad_r              <= rad_nxt;
    root_r             <= root_nxt;
    cnt_r              <= cnt_nxt;
    energy_r           <= energy_nxt;
    k_r                <= k_nxt;
    phase_r            <= phase_nxt;
    opnd_r             <= opnd_nxt;
    acc_r              <= acc_nxt;
    be_r               <= be_nxt;
    total_r            <= total_nxt;
    out_bin_index_r    <= out_bin_index_nxt;
    out_bin_energy_r   <= out_bin_energy_nxt;
    out_total_energy_r <= out_total_energy_nxt;
    out_last_bin_r     <= out_last_bin_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_bin_index    = out_bin_index_r;
  assign out_bin_energy   = out_bin_energy_r;
  assign out_total_energy = out_total_energy_r;
  assign out_last_bin     = out_last_bin_r;

  `RESB_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == resb_pkg::ST_KX, "accepted mode did not start the sequence")
  `RESB_ASSERT_IMPL(a_beat_from_out, $rose(out_valid_r), $past(state_r) == resb_pkg::ST_RO_OUT, "result beat raised outside readout")
  `RESB_ASSERT_NEXT(a_bins_cleared, state_r == resb_pkg::ST_RO_OUT && slot_free && k_r == LAST_K, valid_r == '0, "bins not cleared after readout")
  `RESB_ASSERT_IMPL(a_write_after_read, ram_we, $past(state_r) == resb_pkg::ST_BIN_RD, "bin write without preceding read")

endmodule

@@ design/resb_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module resb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/resb_mul.sv @@
// shared 32x32 unsigned multiplier, product registered
// depends on resb_pkg
module resb_mul (
  input  logic                        clk,
  input  resb_pkg::resb_mul_req_t     req,
  output logic [2*resb_pkg::MUL_W-1:0] prod
);

  logic [2*resb_pkg::MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;

endmodule

@@ bench/tb_radial_energy_spectrum_binner_unit.sv @@
// self-checking bench for radial_energy_spectrum_binner_unit: drives modes, registers and
// result stalls, and predicts every bin beat with a scoreboard class
// depends on resb_pkg and the binner rtl only
`timescale 1ns / 100ps

module tb_radial_energy_spectrum_binner_unit;

  localparam int GRID           = 64;
  localparam int SHELLS         = GRID / 2 + 1;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BURST_MODES    = 12;
  localparam int RANDOM_MODES   = 320;
  localparam logic [resb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [23:0] ux_re;
    logic [23:0] ux_im;
    logic [23:0] uy_re;
    logic [23:0] uy_im;
    logic        last;
  } spectrum_mode_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [63:0] bin_energy;
    logic [63:0] total_energy;
    logic        last_bin;
  } spectrum_beat_t;

  class spectrum_scoreboard;
    logic [31:0]    gain;
    logic [6:0]     shift;
    logic [31:0]    kscale;
    logic [63:0]    shells [SHELLS];
    spectrum_beat_t pending_beats [$];
    int             errors;
    int             beats_checked;

    function new();
      gain = 32'd65536;
      shift = 7'd16;
      kscale = 32'd65536;
      foreach (shells[k]) shells[k] = '0;
      errors = 0;
      beats_checked = 0;
    endfunction

    function logic [63:0] comp_power(logic [23:0] v);
      logic [23:0] mag;
      mag = v[23] ? (~v + 24'd1) : v;
      return {40'd0, mag} * {40'd0, mag};
    endfunction

    function int unsigned floor_root(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    // full product, truncating shift, then clip to 64 bits
    function logic [63:0] mul_shift_clip(logic [63:0] a, logic [31:0] b, logic [6:0] s);
      logic [127:0] p;
      p = {64'd0, a} * {96'd0, b};
      p = p >> s;
      return (p[127:64] != '0) ? '1 : p[63:0];
    endfunction

    function void set_reg(logic [resb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        resb_pkg::REG_OUTPUT_GAIN:      gain = data;
        resb_pkg::REG_GAIN_SHIFT:       shift = data[6:0];
        resb_pkg::REG_WAVENUMBER_SCALE: kscale = data;
        default: ;
      endcase
    endfunction

    function void note_mode(spectrum_mode_t m);
      int unsigned    kx;
      int unsigned    shell;
      logic [63:0]    e;
      logic [63:0]    be;
      logic [63:0]    total;
      spectrum_beat_t b;
      if (m.row < GRID && m.col <= GRID / 2) begin
        kx = (m.row <= GRID / 2) ? m.row : GRID - m.row;
        shell = floor_root(kx * kx + m.col * m.col);
        if (shell < SHELLS) begin
          e = comp_power(m.ux_re) + comp_power(m.ux_im)
            + comp_power(m.uy_re) + comp_power(m.uy_im);
          // conjugate partner of a paired column is not sent
          if (m.col != 0) e = e << 1;
          shells[shell] = add_clip(shells[shell], e);
        end
      end
      if (m.last) begin
        total = '0;
        for (int k = 0; k < SHELLS; k++) begin
          be = mul_shift_clip(shells[k], gain, shift);
          total = add_clip(total, mul_shift_clip(be, kscale, resb_pkg::SCALE_FRAC_BITS));
          b.bin_index = k[5:0];
          b.bin_energy = be;
          b.total_energy = total;
          b.last_bin = (k == SHELLS - 1);
          pending_beats.push_back(b);
          shells[k] = '0;
        end
      end
    endfunction

    function void check_beat(spectrum_beat_t got);
      spectrum_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("bin beat with nothing pending: bin_index %0d", got.bin_index);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (got.bin_index !== want.bin_index) begin
        $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
        errors++;
      end
      if (got.bin_energy !== want.bin_energy) begin
        $error("bin_energy: expected %0h, got %0h", want.bin_energy, got.bin_energy);
        errors++;
      end
      if (got.total_energy !== want.total_energy) begin
        $error("total_energy: expected %0h, got %0h", want.total_energy, got.total_energy);
        errors++;
      end
      if (got.last_bin !== want.last_bin) begin
        $error("last_bin: expected %0b, got %0b", want.last_bin, got.last_bin);
        errors++;
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic [23:0] in_ux_real = '0;
  logic [23:0] in_ux_imag = '0;
  logic [23:0] in_uy_real = '0;
  logic [23:0] in_uy_imag = '0;
  logic        in_last_mode = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_bin_index;
  logic [63:0] out_bin_energy;
  logic [63:0] out_total_energy;
  logic        out_last_bin;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spectrum_scoreboard sb;
  bit steady = 1'b0;
  int n_modes = 0;
  int n_readouts = 0;
  int n_reg_writes = 0;
  int idle_cycles = 0;

  radial_energy_spectrum_binner_unit #(.GRID_SIZE(GRID)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_ux_real       (in_ux_real),
    .in_ux_imag       (in_ux_imag),
    .in_uy_real       (in_uy_real),
    .in_uy_imag       (in_uy_imag),
    .in_last_mode     (in_last_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin_index    (out_bin_index),
    .out_bin_energy   (out_bin_energy),
    .out_total_energy (out_total_energy),
    .out_last_bin     (out_last_bin),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // result side: runs of open cycles broken by stalls, now and then a long open stretch
  initial begin
    int run;
    int hold;
    forever begin
      run = $urandom_range(1, 30);
      if ($urandom_range(0, 7) == 0) run = $urandom_range(80, 200);
      repeat (run) @(posedge clk);
      hold = $urandom_range(0, 9) == 0 ? $urandom_range(8, 60) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat('{out_bin_index, out_bin_energy, out_total_energy, out_last_bin});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_radial_energy_spectrum_binner_unit: errors");
      $finish;
    end
  end

  function automatic spectrum_mode_t mk_mode(int row, int col, logic [23:0] a, logic [23:0] b,
                                             logic [23:0] c, logic [23:0] d, bit last);
    spectrum_mode_t m;
    m.row = row[5:0];
    m.col = col[5:0];
    m.ux_re = a;
    m.ux_im = b;
    m.uy_re = c;
    m.uy_im = d;
    m.last = last;
    return m;
  endfunction

  function automatic logic [23:0] random_comp();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      1: return 24'($urandom_range(0, 511)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic spectrum_mode_t random_mode();
    spectrum_mode_t m;
    m.row = 6'($urandom_range(0, 63));
    // mostly inside the half-plane, some columns past it
    m.col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    m.ux_re = random_comp();
    m.ux_im = random_comp();
    m.uy_re = random_comp();
    m.uy_im = random_comp();
    m.last = ($urandom_range(0, 19) == 0);
    return m;
  endfunction

  task automatic send_mode(input spectrum_mode_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_index <= m.row;
    in_col_index <= m.col;
    in_ux_real   <= m.ux_re;
    in_ux_imag   <= m.ux_im;
    in_uy_real   <= m.uy_re;
    in_uy_imag   <= m.uy_im;
    in_last_mode <= m.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_mode(m);
    n_modes++;
    if (m.last) n_readouts++;
  endtask

  task automatic put_reg(input logic [resb_pkg::CFG_IDX_W-1:0] idx,
                         input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    n_reg_writes++;
  endtask

  task automatic program_regs(input logic [31:0] gain, input logic [31:0] shift_word,
                              input logic [31:0] kscale, input bit poke_unused);
    put_reg(resb_pkg::REG_OUTPUT_GAIN, gain);
    if (poke_unused) put_reg(REG_UNUSED, $urandom);
    put_reg(resb_pkg::REG_GAIN_SHIFT, shift_word);
    put_reg(resb_pkg::REG_WAVENUMBER_SCALE, kscale);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every bin beat is back and the last mode has cleared the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    spectrum_mode_t m;
    logic [31:0]    gain;
    logic [31:0]    shift_word;
    logic [31:0]    kscale;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: Nyquist edges, dropped modes, a dropped last mode
    send_mode(mk_mode(0, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 0));
    send_mode(mk_mode(32, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
    send_mode(mk_mode(33, 1, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 0));
    send_mode(mk_mode(63, 32, 24'h000100, 24'hFFFF00, 24'h0, 24'h0, 0));
    send_mode(mk_mode(32, 32, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
    send_mode(mk_mode(10, 33, 24'h123456, 24'h654321, 24'hABCDEF, 24'h0F0F0F, 0));
    send_mode(mk_mode(5, 63, 24'h555555, 24'hAAAAAA, 24'h333333, 24'hCCCCCC, 0));
    send_mode(mk_mode(3, 4, 24'h000010, 24'hFFFFF0, 24'h000200, 24'hFFFE00, 0));
    send_mode(mk_mode(32, 24, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 1));
    settle();

    // widest gain, no shift, widest scale: bins and total clip
    program_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1);
    send_mode(mk_mode(0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
    send_mode(mk_mode(1, 1, 24'h000001, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 0));
    send_mode(mk_mode(0, 2, 24'h0, 24'h0, 24'h0, 24'h0, 1));
    settle();

    // zero gain and scale, shift field with junk above bit 6
    program_regs(32'h0, {25'h1FF_FFFF, 7'd127}, 32'h0, 0);
    send_mode(mk_mode(20, 20, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1));
    settle();
    program_regs(32'h1, 32'd96, 32'd65536, 0);
    send_mode(mk_mode(0, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 1));
    settle();
    program_regs(32'hFFFF_FFFF, 32'd95, 32'd65536, 1);
    send_mode(mk_mode(0, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 1));
    settle();
    program_regs(32'hFFFF_FFFF, 32'd64, 32'd12345, 0);
    send_mode(mk_mode(2, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 0));
    send_mode(mk_mode(0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 1));
    settle();

    // burst of full-scale paired modes into one shell, sent back to back
    program_regs(32'h1, 32'h0, 32'd65536, 0);
    steady = 1'b1;
    for (int i = 0; i < BURST_MODES; i++)
      send_mode(mk_mode(0, 1, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                        i == BURST_MODES - 1));
    steady = 1'b0;
    settle();

    for (int i = 0; i < RANDOM_MODES; i++) begin
      if ($urandom_range(0, 39) == 0) steady = ~steady;
      m = random_mode();
      if (i == RANDOM_MODES - 1) m.last = 1'b1;
      send_mode(m);
      if (m.last && $urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0: gain = 32'h0;
          1: gain = 32'hFFFF_FFFF;
          2: gain = 32'h1;
          3: gain = 32'd65536;
          default: gain = $urandom;
        endcase
        shift_word = $urandom;
        case ($urandom_range(0, 5))
          0: shift_word[6:0] = 7'd0;
          1: shift_word[6:0] = 7'd127;
          2: shift_word[6:0] = 7'd95;
          3: shift_word[6:0] = 7'd96;
          default: shift_word[6:0] = 7'($urandom_range(8, 64));
        endcase
        case ($urandom_range(0, 4))
          0: kscale = 32'h0;
          1: kscale = 32'hFFFF_FFFF;
          2: kscale = 32'd65536;
          default: kscale = $urandom;
        endcase
        program_regs(gain, shift_word, kscale, $urandom_range(0, 3) == 0);
      end
    end
    settle();

    $display("run covered %0d modes, %0d spectrum readouts and %0d register writes",
             n_modes, n_readouts, n_reg_writes);
    $display("%0d bin beats checked, with clipping gains and a back-to-back burst",
             sb.beats_checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_radial_energy_spectrum_binner_unit: clean");
    else
      $display("tb_radial_energy_spectrum_binner_unit: errors");
    $finish;
  end

endmodule
